// File: hw/rtl/lcls_pkg.sv
// Shared types, constants and command-word matching for the line command light switch.
package lcls_pkg;

    // Line storage capacity; a line ends once it holds LINE_CAPACITY-1 bytes
    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    // Control characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // Command words, first character in the top byte
    localparam logic [31:0] WORD_L1ON  = "L1ON";
    localparam logic [39:0] WORD_L1OFF = "L1OFF";
    localparam logic [31:0] WORD_L2ON  = "L2ON";
    localparam logic [39:0] WORD_L2OFF = "L2OFF";
    localparam logic [31:0] WORD_L3ON  = "L3ON";
    localparam logic [39:0] WORD_L3OFF = "L3OFF";

    // Number of command words, one seen flag each
    localparam int NUM_CMDS = 6;

    // Reported command codes
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_L1ON  = 3'd1,
        CMD_L1OFF = 3'd2,
        CMD_L2ON  = 3'd3,
        CMD_L2OFF = 3'd4,
        CMD_L3ON  = 3'd5,
        CMD_L3OFF = 3'd6
    } t_cmd;

    // Last four bytes of the line, entry 0 the newest
    typedef logic [3:0][7:0] t_hist;

    // Line-end event passed from the line tracker to the light control
    typedef struct packed {
        logic                valid;
        logic                full;
        logic [NUM_CMDS-1:0] flags;
    } t_line_end;

    // Four-character word ends with the new byte
    function automatic logic tail_is4(input logic [7:0] c, input t_hist hist,
                                      input logic [31:0] word);
        return (c == word[7:0]) && (hist[0] == word[15:8]) &&
               (hist[1] == word[23:16]) && (hist[2] == word[31:24]);
    endfunction

    // Five-character word ends with the new byte
    function automatic logic tail_is5(input logic [7:0] c, input t_hist hist,
                                      input logic [39:0] word);
        return (c == word[7:0]) && (hist[0] == word[15:8]) &&
               (hist[1] == word[23:16]) && (hist[2] == word[31:24]) &&
               (hist[3] == word[39:32]);
    endfunction

endpackage

// File: hw/rtl/line_command_light_switch_top.sv
// Top level of the line command light switch: input register and the two processing parts.
// Takes one received byte per cycle and gathers bytes into lines; NUL bytes are dropped,
// a CR or LF ends a non-empty line, and a line also ends when it holds LINE_CAPACITY-1
// bytes. While a line builds, the newest byte and the four before it are compared against
// L1ON, L1OFF, L2ON, L2OFF, L3ON and L3OFF; at line end the first seen command in that
// order switches its light, and one result word gives the three light states, the command
// code (0 for none) and whether the line ended full. A byte is held in the input register;
// when the final byte of a line advances, the line's result is loaded into the output
// register. One byte is taken every cycle as long as the output register is free or
// being read. No clearing pass after reset.
module line_command_light_switch_top
    import lcls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_light_one_on,
    output logic       o_light_two_on,
    output logic       o_light_three_on,
    output logic [2:0] o_matched_command,
    output logic       o_line_was_full
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    t_line_end  line_end;

    // Advance the held byte when the result register has room
    assign step       = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    lcls_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_end   (line_end)
    );

    lcls_lights u_lights (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_end             (line_end),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_light_one_on    (o_light_one_on),
        .o_light_two_on    (o_light_two_on),
        .o_light_three_on  (o_light_three_on),
        .o_matched_command (o_matched_command),
        .o_line_was_full   (o_line_was_full)
    );

endmodule

// File: hw/rtl/lcls_line.sv
// Line tracker: byte history, line length, command seen flags and line-end detection.
module lcls_line
    import lcls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_line_end  o_end
);

    t_hist               r_hist, n_hist;
    logic [LEN_W-1:0]    r_len,  n_len;
    logic [NUM_CMDS-1:0] r_flags, n_flags;
    logic [NUM_CMDS-1:0] hits;
    logic [LEN_W-1:0]    len_inc;
    logic                is_term;

    // Compare the new byte and the history against every command word
    always_comb begin
        hits[0] = tail_is4(i_byte, r_hist, WORD_L1ON);
        hits[1] = tail_is5(i_byte, r_hist, WORD_L1OFF);
        hits[2] = tail_is4(i_byte, r_hist, WORD_L2ON);
        hits[3] = tail_is5(i_byte, r_hist, WORD_L2OFF);
        hits[4] = tail_is4(i_byte, r_hist, WORD_L3ON);
        hits[5] = tail_is5(i_byte, r_hist, WORD_L3OFF);
    end

    assign is_term = (i_byte == CHAR_LF) || (i_byte == CHAR_CR);
    assign len_inc = r_len + LEN_W'(1);

    // Append the byte or end the line
    always_comb begin
        n_hist  = r_hist;
        n_len   = r_len;
        n_flags = r_flags;
        o_end   = '{valid: 1'b0, full: 1'b0, flags: r_flags};
        if (i_step && (i_byte != CHAR_NUL)) begin
            if (is_term) begin
                if (r_len != '0) begin
                    o_end   = '{valid: 1'b1, full: 1'b0, flags: r_flags};
                    n_hist  = '0;
                    n_len   = '0;
                    n_flags = '0;
                end
            end else if (len_inc == LEN_W'(LINE_CAPACITY - 1)) begin
                o_end   = '{valid: 1'b1, full: 1'b1, flags: r_flags | hits};
                n_hist  = '0;
                n_len   = '0;
                n_flags = '0;
            end else begin
                n_hist  = {r_hist[2:0], i_byte};
                n_len   = len_inc;
                n_flags = r_flags | hits;
            end
        end
    end

    // Hold the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_len   <= '0;
            r_flags <= '0;
        end else begin
            r_hist  <= n_hist;
            r_len   <= n_len;
            r_flags <= n_flags;
        end
    end

    // The stored length never reaches the end-of-line count
    a_len_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != LEN_W'(LINE_CAPACITY - 1))
        else $error("line length reached capacity");

    // A line end leaves an empty line behind
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end.valid |=> (r_len == '0) && (r_flags == '0) && (r_hist == '0))
        else $error("line state not cleared after line end");

    // A line end only comes from a step with a non-empty line or a full one
    a_end_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end.valid |-> i_step && ((r_len != '0) || o_end.full))
        else $error("line end without a pending line");

endmodule

// File: hw/rtl/lcls_lights.sv
// Light control: command priority, light state and the result register.
module lcls_lights
    import lcls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_line_end i_end,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output logic      o_light_one_on,
    output logic      o_light_two_on,
    output logic      o_light_three_on,
    output logic [2:0] o_matched_command,
    output logic      o_line_was_full
);

    logic [2:0] r_lights, n_lights;
    logic       r_out_valid;
    logic [2:0] r_out_lights;
    t_cmd       r_out_cmd;
    logic       r_out_full;
    t_cmd       code;

    // Pick the first seen command in fixed order
    always_comb begin
        priority if (i_end.flags[0]) code = CMD_L1ON;
        else if     (i_end.flags[1]) code = CMD_L1OFF;
        else if     (i_end.flags[2]) code = CMD_L2ON;
        else if     (i_end.flags[3]) code = CMD_L2OFF;
        else if     (i_end.flags[4]) code = CMD_L3ON;
        else if     (i_end.flags[5]) code = CMD_L3OFF;
        else                         code = CMD_NONE;
    end

    // Switch the addressed light
    always_comb begin
        n_lights = r_lights;
        unique case (code)
            CMD_L1ON:  n_lights[0] = 1'b1;
            CMD_L1OFF: n_lights[0] = 1'b0;
            CMD_L2ON:  n_lights[1] = 1'b1;
            CMD_L2OFF: n_lights[1] = 1'b0;
            CMD_L3ON:  n_lights[2] = 1'b1;
            CMD_L3OFF: n_lights[2] = 1'b0;
            default:   n_lights = r_lights;
        endcase
    end

    // Hold the lights and the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lights    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_end.valid) begin
                r_lights    <= n_lights;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (i_end.valid) begin
            r_out_lights <= n_lights;
            r_out_cmd    <= code;
            r_out_full   <= i_end.full;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_light_one_on    = r_out_lights[0];
    assign o_light_two_on    = r_out_lights[1];
    assign o_light_three_on  = r_out_lights[2];
    assign o_matched_command = r_out_cmd;
    assign o_line_was_full   = r_out_full;

    // A new line end never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end.valid |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // A line with no command leaves the lights alone
    a_none_keeps_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_end.valid && (code == CMD_NONE)) |=> $stable(r_lights))
        else $error("lights changed without a command");

    // Reported lights match the held light state
    a_out_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lights == r_lights))
        else $error("reported lights differ from light state");

endmodule

// File: tb/line_command_light_switch_checker.sv
// Checker for the line command light switch: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module line_command_light_switch_checker
    import lcls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_light_one_on,
    input  logic       i_light_two_on,
    input  logic       i_light_three_on,
    input  logic [2:0] i_matched_command,
    input  logic       i_line_was_full,
    output int         o_mismatches,
    output int         o_pending
);

    // Command spellings, first character in the top byte
    localparam logic [31:0] TXT_L1ON  = "L1ON";
    localparam logic [39:0] TXT_L1OFF = "L1OFF";
    localparam logic [31:0] TXT_L2ON  = "L2ON";
    localparam logic [39:0] TXT_L2OFF = "L2OFF";
    localparam logic [31:0] TXT_L3ON  = "L3ON";
    localparam logic [39:0] TXT_L3OFF = "L3OFF";

    typedef struct {
        logic [2:0] lamps;
        t_cmd       cmd;
        logic       full;
    } t_switch_word;

    t_switch_word switch_words_q[$];

    // Predicted state of the block
    logic [2:0]  lamp_state;
    int unsigned line_len;
    logic [7:0]  tail_bytes [4];
    logic [5:0]  seen_cmds;

    int mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_line();
        line_len   = 0;
        tail_bytes = '{default: 8'h00};
        seen_cmds  = '0;
    endtask

    // End the line: the first seen command switches its lamp, then queue the word
    task automatic close_line(input logic full);
        t_cmd         code;
        t_switch_word w;
        if (seen_cmds[0])      code = CMD_L1ON;
        else if (seen_cmds[1]) code = CMD_L1OFF;
        else if (seen_cmds[2]) code = CMD_L2ON;
        else if (seen_cmds[3]) code = CMD_L2OFF;
        else if (seen_cmds[4]) code = CMD_L3ON;
        else if (seen_cmds[5]) code = CMD_L3OFF;
        else                   code = CMD_NONE;
        case (code)
            CMD_L1ON:  lamp_state[0] = 1'b1;
            CMD_L1OFF: lamp_state[0] = 1'b0;
            CMD_L2ON:  lamp_state[1] = 1'b1;
            CMD_L2OFF: lamp_state[1] = 1'b0;
            CMD_L3ON:  lamp_state[2] = 1'b1;
            CMD_L3OFF: lamp_state[2] = 1'b0;
            default: ;
        endcase
        w.lamps = lamp_state;
        w.cmd   = code;
        w.full  = full;
        switch_words_q.push_back(w);
        clear_line();
    endtask

    // Fold one accepted byte into the line being gathered
    task automatic absorb_byte(input logic [7:0] c);
        logic [31:0] last4;
        logic [39:0] last5;
        if (c == CHAR_NUL)
            return;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (line_len > 0)
                close_line(1'b0);
            return;
        end
        last4 = {tail_bytes[2], tail_bytes[1], tail_bytes[0], c};
        last5 = {tail_bytes[3], last4};
        seen_cmds |= {last5 == TXT_L3OFF, last4 == TXT_L3ON,
                      last5 == TXT_L2OFF, last4 == TXT_L2ON,
                      last5 == TXT_L1OFF, last4 == TXT_L1ON};
        tail_bytes[3] = tail_bytes[2];
        tail_bytes[2] = tail_bytes[1];
        tail_bytes[1] = tail_bytes[0];
        tail_bytes[0] = c;
        line_len++;
        if (line_len >= LINE_CAPACITY - 1)
            close_line(1'b1);
    endtask

    // Compare leaving words first, then predict from the arriving byte
    always @(posedge i_clk) begin
        t_switch_word w;
        if (!i_rst_n) begin
            lamp_state = '0;
            clear_line();
            switch_words_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (switch_words_q.size() == 0) begin
                    report_mismatch("unexpected word, command", i_matched_command, -1);
                end else begin
                    w = switch_words_q.pop_front();
                    if (i_light_one_on !== w.lamps[0])
                        report_mismatch("light_one_on", i_light_one_on, w.lamps[0]);
                    if (i_light_two_on !== w.lamps[1])
                        report_mismatch("light_two_on", i_light_two_on, w.lamps[1]);
                    if (i_light_three_on !== w.lamps[2])
                        report_mismatch("light_three_on", i_light_three_on, w.lamps[2]);
                    if (i_matched_command !== w.cmd)
                        report_mismatch("matched_command", i_matched_command, w.cmd);
                    if (i_line_was_full !== w.full)
                        report_mismatch("line_was_full", i_line_was_full, w.full);
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_byte(i_rx_byte);
        end
        o_pending = switch_words_q.size();
    end

endmodule

// File: tb/line_command_light_switch_top_tb.sv
// Testbench top for the line command light switch: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module line_command_light_switch_top_tb;
    import lcls_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int TARGET_BYTES = 1650;
    localparam int QUIET_FROM   = 1450;
    localparam int HOLD_FROM    = 500;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       light_one_on;
    logic       light_two_on;
    logic       light_three_on;
    logic [2:0] matched_command;
    logic       line_was_full;

    int mismatches;
    int pending;

    // Stimulus bookkeeping; the quiet and hold flags are shared with the drain side
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    int bytes_taken = 0;
    int open_len    = 0;

    always #5 clk = ~clk;

    line_command_light_switch_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_light_one_on   (light_one_on),
        .o_light_two_on   (light_two_on),
        .o_light_three_on (light_three_on),
        .o_matched_command(matched_command),
        .o_line_was_full  (line_was_full)
    );

    line_command_light_switch_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_light_one_on   (light_one_on),
        .i_light_two_on   (light_two_on),
        .i_light_three_on (light_three_on),
        .i_matched_command(matched_command),
        .i_line_was_full  (line_was_full),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // Offer one byte, hold it until taken; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        // Count only bytes the block acts on
        if (b == CHAR_CR || b == CHAR_LF) begin
            if (open_len > 0) begin
                bytes_taken++;
                open_len = 0;
            end
        end else if (b != CHAR_NUL) begin
            bytes_taken++;
            open_len++;
            if (open_len >= LINE_CAPACITY - 1)
                open_len = 0;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Occasionally slip a NUL in ahead of a byte
    task automatic send_loose(input logic [7:0] b);
        if ($urandom_range(0, 29) == 0)
            send_byte(CHAR_NUL);
        send_byte(b);
    endtask

    // Filler biased towards the letters of the commands, for near misses
    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 11))
            0:       return "L";
            1:       return "O";
            2:       return "N";
            3:       return "F";
            4:       return "1";
            5:       return "2";
            6:       return "3";
            7:       return " ";
            default: return 8'($urandom_range(8'h0E, 8'hFF));
        endcase
    endfunction

    function automatic string pick_command();
        case ($urandom_range(0, 5))
            0:       return "L1ON";
            1:       return "L1OFF";
            2:       return "L2ON";
            3:       return "L2OFF";
            4:       return "L3ON";
            default: return "L3OFF";
        endcase
    endfunction

    // Send a command, now and then with one character spoilt
    task automatic send_command(input string s);
        int spoil;
        spoil = ($urandom_range(0, 7) == 0) ? $urandom_range(0, s.len() - 1) : -1;
        for (int i = 0; i < s.len(); i++)
            send_loose(i == spoil ? filler_byte() : s[i]);
    endtask

    // One line: mostly well formed, some running to capacity, some noise
    task automatic send_random_line();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 40))
                send_byte(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            repeat ($urandom_range(28, 40)) begin
                if ($urandom_range(0, 5) == 0)
                    send_command(pick_command());
                else
                    send_loose(filler_byte());
            end
        end else begin
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(0, 4))
                    send_loose(filler_byte());
                send_command(pick_command());
            end
            repeat ($urandom_range(0, 3))
                send_loose(filler_byte());
            case ($urandom_range(0, 5))
                0, 1, 2: send_byte(CHAR_LF);
                3, 4:    send_byte(CHAR_CR);
                default: begin
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
            endcase
        end
    endtask

    // Drain side: random stalls, one long hold-off, none once quiet
    initial begin : drain_side
        int n;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (quiet) begin
                out_ready <= 1'b1;
                @(negedge clk);
            end else if ($urandom_range(0, 3) != 0) begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(negedge clk);
            end else begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
            end
        end
    end

    // Feed side and verdict
    initial begin : feed_side
        int waited;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored bytes, commands, NUL inside a word, top byte value
        send_byte(CHAR_NUL);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_text("L1ON");
        send_byte(CHAR_LF);
        send_text("L3OF");
        send_byte(CHAR_NUL);
        send_text("F");
        send_byte(CHAR_CR);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_text("L2ON");
        send_byte(CHAR_CR);

        // Random lines until enough bytes have gone in
        while (bytes_taken < TARGET_BYTES) begin
            if (bytes_taken >= HOLD_FROM)
                hold_req = 1'b1;
            if (bytes_taken >= QUIET_FROM)
                quiet = 1'b1;
            send_random_line();
        end
        in_valid <= 1'b0;

        // Drain what is still owed, then give stray words a chance to show
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("line_command_light_switch_top regression: pass");
        else
            $display("line_command_light_switch_top regression: fail");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("line_command_light_switch_top regression: fail");
        $finish;
    end

endmodule
